@@ design/dxt_block_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// dxt block decoder assertion macros
// Shared property shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_DEFINES_SVH
`define DXT_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication
`define DXT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DXT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dxt_pkg.sv @@
// ----------------------------------------------------------------------------
// dxt_pkg
// Types, format codes and fixed-point helpers of the S3TC block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_e;

  localparam int unsigned TexelsPerBlock = 16;

  // per channel: [0] red, [1] green, [2] blue, [3] alpha
  typedef logic [3:0][7:0] rgba_t;

  typedef struct packed {
    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic            four;
    fmt_e            mode;
    logic [31:0]     cidx;
    logic [63:0]     aword;
  } blk_t;

  typedef struct packed {
    rgba_t [3:0]     color;
    logic [7:0][7:0] apal;
    fmt_e            mode;
    logic [31:0]     cidx;
    logic [63:0]     aword;
  } pal_t;

  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_texel;
  } texel_t;

  typedef struct packed {
    logic take;
    logic done;
  } emit_stat_t;

  // round(c*255/31) through a reciprocal multiply
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] x;
    logic [26:0] p;
    x = {8'd0, c} * 13'd255 + 13'd15;
    p = {14'd0, x} * 27'd8457;
    return p[25:18];
  endfunction

  // round(c*255/63)
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] x;
    logic [28:0] p;
    x = {8'd0, c} * 14'd255 + 14'd31;
    p = {15'd0, x} * 29'd16645;
    return p[27:20];
  endfunction

  // floor(x/3) for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  // floor(x/5) for x below 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd3277;
    return p[21:14];
  endfunction

  // floor(x/7) for x below 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd2341;
    return p[21:14];
  endfunction

endpackage

@@ design/dxt_block_if.sv @@
// ----------------------------------------------------------------------------
// dxt_block_if
// Compressed block channel: one transfer carries a whole 4x4 block.
// ----------------------------------------------------------------------------
interface dxt_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] color_word;
  logic [63:0] alpha_word;

  modport source (output valid, output color_word, output alpha_word, input ready);
  modport sink (input valid, input color_word, input alpha_word, output ready);
endinterface

@@ design/dxt_texel_if.sv @@
// ----------------------------------------------------------------------------
// dxt_texel_if
// Decoded texel channel: one RGBA8 texel per word.
// ----------------------------------------------------------------------------
interface dxt_texel_if;
  logic       valid;
  logic       ready;
  logic [3:0] texel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_texel;

  modport source (
    output valid, output texel_index, output red, output green, output blue,
    output alpha, output last_texel, input ready
  );
  modport sink (
    input valid, input texel_index, input red, input green, input blue,
    input alpha, input last_texel, output ready
  );
endinterface

@@ design/dxt_blk_reg.sv @@
// ----------------------------------------------------------------------------
// dxt_blk_reg
// Input register: expands the RGB565 endpoints and picks the color mode.
// ----------------------------------------------------------------------------
module dxt_blk_reg import dxt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] color_word_i,
  input  logic [63:0] alpha_word_i,
  input  logic [1:0]  format_i,
  output logic        ready_o,
  input  logic        ready_i,
  output logic        valid_o,
  output blk_t        blk_o
);

  logic        valid_q, valid_d;
  logic        load;
  blk_t        blk_q, blk_d;
  logic [15:0] c0, c1;
  fmt_e        mode;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    // code 3 behaves as DXT5
    if (format_i[1]) begin
      mode = FMT_DXT5;
    end else if (format_i[0]) begin
      mode = FMT_DXT3;
    end else begin
      mode = FMT_DXT1;
    end
  end

  always_comb begin
    c0 = color_word_i[15:0];
    c1 = color_word_i[31:16];
    blk_d.e0[0] = expand5(c0[15:11]);
    blk_d.e0[1] = expand6(c0[10:5]);
    blk_d.e0[2] = expand5(c0[4:0]);
    blk_d.e1[0] = expand5(c1[15:11]);
    blk_d.e1[1] = expand6(c1[10:5]);
    blk_d.e1[2] = expand5(c1[4:0]);
    blk_d.four  = (mode != FMT_DXT1) || (c0 > c1);
    blk_d.mode  = mode;
    blk_d.cidx  = color_word_i[63:32];
    blk_d.aword = alpha_word_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

@@ design/dxt_palette.sv @@
// ----------------------------------------------------------------------------
// dxt_palette
// Builds the 4-entry color palette and the 8-entry alpha palette of a block.
// ----------------------------------------------------------------------------
module dxt_palette import dxt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  blk_t       blk_i,
  output logic       ready_o,
  input  emit_stat_t stat_i,
  output logic       valid_o,
  output pal_t       pal_o
);

  logic        valid_q, valid_d;
  logic        load;
  pal_t        pal_q, pal_d;
  logic [9:0]  s2 [3];
  logic [9:0]  s3 [3];
  logic [8:0]  sh [3];
  logic [10:0] w7 [1:6];
  logic [10:0] w5 [1:4];
  logic [7:0]  a0, a1;

  // free once the last texel of the current block leaves
  assign ready_o = !valid_q || stat_i.done;
  assign load    = valid_i && ready_o;

  always_comb begin
    pal_d.mode  = blk_i.mode;
    pal_d.cidx  = blk_i.cidx;
    pal_d.aword = blk_i.aword;

    pal_d.color[0] = {8'hff, blk_i.e0[2], blk_i.e0[1], blk_i.e0[0]};
    pal_d.color[1] = {8'hff, blk_i.e1[2], blk_i.e1[1], blk_i.e1[0]};
    for (int ch = 0; ch < 3; ch++) begin
      s2[ch] = {1'b0, blk_i.e0[ch], 1'b0} + {2'b0, blk_i.e1[ch]} + 10'd1;
      s3[ch] = {2'b0, blk_i.e0[ch]} + {1'b0, blk_i.e1[ch], 1'b0} + 10'd1;
      sh[ch] = {1'b0, blk_i.e0[ch]} + {1'b0, blk_i.e1[ch]} + 9'd1;
      pal_d.color[2][ch] = blk_i.four ? div3(s2[ch]) : sh[ch][8:1];
      pal_d.color[3][ch] = blk_i.four ? div3(s3[ch]) : 8'd0;
    end
    pal_d.color[2][3] = 8'hff;
    // three-color mode: last entry is transparent black
    pal_d.color[3][3] = blk_i.four ? 8'hff : 8'h00;

    a0 = blk_i.aword[7:0];
    a1 = blk_i.aword[15:8];
    for (int k = 1; k <= 6; k++) begin
      w7[k] = 11'(7 - k) * {3'b0, a0} + 11'(k) * {3'b0, a1} + 11'd3;
    end
    for (int k = 1; k <= 4; k++) begin
      w5[k] = 11'(5 - k) * {3'b0, a0} + 11'(k) * {3'b0, a1} + 11'd2;
    end
    pal_d.apal[0] = a0;
    pal_d.apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        pal_d.apal[k + 1] = div7(w7[k]);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        pal_d.apal[k + 1] = div5(w5[k]);
      end
      pal_d.apal[6] = 8'h00;
      pal_d.apal[7] = 8'hff;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (stat_i.done) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pal_q <= pal_d;
    end
  end

  assign valid_o = valid_q;
  assign pal_o   = pal_q;

endmodule

@@ design/dxt_texel_emit.sv @@
// ----------------------------------------------------------------------------
// dxt_texel_emit
// Walks the 16 texels of the held palette into the output register.
// ----------------------------------------------------------------------------
module dxt_texel_emit import dxt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pal_valid_i,
  input  pal_t       pal_i,
  output emit_stat_t stat_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output texel_t     texel_o
);

  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  texel_t     texel_q, texel_d;
  logic       emit;
  logic [1:0] ci;
  rgba_t      entry;
  logic [3:0] nib;
  logic [5:0] apos;
  logic [2:0] aidx;
  logic [7:0] alpha;

  assign emit = pal_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    ci    = pal_i.cidx[{cnt_q, 1'b0} +: 2];
    entry = pal_i.color[ci];
    nib   = pal_i.aword[{cnt_q, 2'b00} +: 4];
    // dxt5 index of texel n starts at bit 16 + 3n
    apos  = 6'd16 + {2'b0, cnt_q} + {1'b0, cnt_q, 1'b0};
    aidx  = pal_i.aword[apos +: 3];
    case (pal_i.mode)
      FMT_DXT1: alpha = entry[3];
      FMT_DXT3: alpha = {nib, nib};
      default:  alpha = pal_i.apal[aidx];
    endcase
    texel_d.texel_index = cnt_q;
    texel_d.red         = entry[0];
    texel_d.green       = entry[1];
    texel_d.blue        = entry[2];
    texel_d.alpha       = alpha;
    texel_d.last_texel  = (cnt_q == 4'(TexelsPerBlock - 1));
  end

  always_comb begin
    cnt_d       = emit ? cnt_q + 4'd1 : cnt_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      texel_q <= texel_d;
    end
  end

  assign stat_o.take = emit;
  assign stat_o.done = emit && (cnt_q == 4'(TexelsPerBlock - 1));
  assign out_valid_o = out_valid_q;
  assign texel_o     = texel_q;

endmodule

@@ design/dxt_block_decoder.sv @@
// ----------------------------------------------------------------------------
// dxt_block_decoder: S3TC DXT1/DXT3/DXT5 4x4 block to 16 RGBA8 texels
// Path: a taken block word goes to the input register, then the palette register.
// Throughput: one texel a cycle while the output is ready, set by the texel
// counter draining the palette register into the output register.
// Reset clears all valid flags, the texel counter and the format (DXT1).
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_defines.svh"

module dxt_block_decoder import dxt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  dxt_block_if.sink   blk_i,
  dxt_texel_if.source texel_o
);

  logic [1:0] block_format_q, block_format_d;
  logic       blk_valid;
  blk_t       blk;
  logic       pal_ready;
  logic       pal_valid;
  pal_t       pal;
  emit_stat_t stat;
  texel_t     texel;

  assign block_format_d = cfg_we_i ? cfg_wdata_i : block_format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_format_q <= FMT_DXT1;
    end else begin
      block_format_q <= block_format_d;
    end
  end

  dxt_blk_reg u_blk_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (blk_i.valid),
    .color_word_i (blk_i.color_word),
    .alpha_word_i (blk_i.alpha_word),
    .format_i     (block_format_q),
    .ready_o      (blk_i.ready),
    .ready_i      (pal_ready),
    .valid_o      (blk_valid),
    .blk_o        (blk)
  );

  dxt_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (blk_valid),
    .blk_i   (blk),
    .ready_o (pal_ready),
    .stat_i  (stat),
    .valid_o (pal_valid),
    .pal_o   (pal)
  );

  dxt_texel_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pal_valid_i (pal_valid),
    .pal_i       (pal),
    .stat_o      (stat),
    .out_ready_i (texel_o.ready),
    .out_valid_o (texel_o.valid),
    .texel_o     (texel)
  );

  assign texel_o.texel_index = texel.texel_index;
  assign texel_o.red         = texel.red;
  assign texel_o.green       = texel.green;
  assign texel_o.blue        = texel.blue;
  assign texel_o.alpha       = texel.alpha;
  assign texel_o.last_texel  = texel.last_texel;

  `DXT_ASSERT_NOW(a_last_marks_end, texel_o.valid, texel_o.last_texel == (texel_o.texel_index == 4'hf), "last_texel out of step with texel_index")
  `DXT_ASSERT_NOW(a_input_holds, blk_valid && !pal_ready, !blk_i.ready, "block word taken over a full input register")
  `DXT_ASSERT_NEXT(a_palette_freed, stat.done && !blk_valid, !pal_valid, "palette still held after its last texel")
  `DXT_ASSERT_NOW(a_emit_needs_palette, stat.take, pal_valid, "texel emitted without a palette")

endmodule
